>>> rtl/gves_pkg.sv
package gves_pkg;

  // request to the shared multiply / divide unit
  typedef struct packed {
    logic start;
    logic div_mode;
  } gves_req_t;

  localparam int ACC_W = 99;
  localparam int OPA_W = 67;

  // configuration register indexes
  localparam logic [2:0] CFG_MODEL_SELECT    = 3'd0;
  localparam logic [2:0] CFG_SCENARIO        = 3'd1;
  localparam logic [2:0] CFG_EFFICACY        = 3'd2;
  localparam logic [2:0] CFG_INFECTIVITY     = 3'd3;
  localparam logic [2:0] CFG_ECLIPSE         = 3'd4;
  localparam logic [2:0] CFG_DEATH           = 3'd5;
  localparam logic [2:0] CFG_CLEARANCE       = 3'd6;
  localparam logic [2:0] CFG_PRODUCTION      = 3'd7;

  // event codes
  localparam logic [2:0] KIND_INFECT  = 3'd0;
  localparam logic [2:0] KIND_ECLIPSE = 3'd1;
  localparam logic [2:0] KIND_DEATH   = 3'd2;
  localparam logic [2:0] KIND_PROD    = 3'd3;
  localparam logic [2:0] KIND_CLEAR   = 3'd4;
  localparam logic [2:0] KIND_NONE    = 3'd5;

  localparam logic [1:0] SCEN_PROD_CUT  = 2'd0;
  localparam logic [1:0] SCEN_INFEC_CUT = 2'd1;
  localparam logic [1:0] SCEN_CLEAR_UP  = 2'd2;

endpackage

>>> rtl/gves_unit.sv
module gves_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gves_pkg::gves_req_t       req,
  input  logic [gves_pkg::OPA_W-1:0] opa,
  input  logic [31:0]               opb,
  output logic                      done,
  output logic [gves_pkg::ACC_W-1:0] result
);
  import gves_pkg::*;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [OPA_W-1:0] a_r, a_nxt;
  logic [31:0]      b_r, b_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             div_r, div_nxt;
  logic             done_r, done_nxt;
  logic [17:0]      rem;
  logic [17:0]      rem_sub;

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    div_nxt  = div_r;
    done_nxt = 1'b0;
    rem      = {acc_r[16:0], a_r[63]};
    rem_sub  = rem - {1'b0, b_r[16:0]};
    if (req.start) begin
      acc_nxt  = '0;
      a_nxt    = opa;
      b_nxt    = opb;
      div_nxt  = req.div_mode;
      cnt_nxt  = req.div_mode ? 7'd64 : 7'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (div_r) begin
        // restoring division, one quotient bit a cycle
        if (rem >= {1'b0, b_r[16:0]}) begin
          acc_nxt = {{(ACC_W-18){1'b0}}, rem_sub};
          a_nxt   = {a_r[OPA_W-2:0], 1'b1};
        end else begin
          acc_nxt = {{(ACC_W-18){1'b0}}, rem};
          a_nxt   = {a_r[OPA_W-2:0], 1'b0};
        end
      end else begin
        // shift-add, multiplier bits MSB first
        acc_nxt = {acc_r[ACC_W-2:0], 1'b0} +
                  (b_r[31] ? {{(ACC_W-OPA_W){1'b0}}, a_r} : '0);
        b_nxt   = {b_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      div_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      div_r  <= div_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done   = done_r;
  assign result = div_r ? {{(ACC_W-64){1'b0}}, a_r[63:0]} : acc_r;

endmodule

>>> rtl/gillespie_viral_infection_step.sv
// One Gillespie event step per request on a shared shift-add multiplier that also runs
// restoring division. An event request runs up to eight multiplies: the rate cut of the
// scenario, the six count products and draw times total rate. The clearance-increase
// scenario adds the divide. Around them sit the skipped operations, the summing of the
// five rates, the event selection and the update and output steps. A request that
// finds a zero total rate ends after the sum with no draw product. A restart, a
// request after the run is over, or one that finds the run ended goes from idle
// straight to the output step.
// in_ready is high only while the block is idle; a finished result waits in the output
// register, and the next request is taken meanwhile but waits in its own output step
// until that result is taken. Configuration is to be written by the user through the
// cfg channel while idle; the block does not enforce it. cfg_ready is always high.
module gillespie_viral_infection_step #(
  parameter int INITIAL_TARGETS = 4000,
  parameter int INITIAL_VIRUS   = 1,
  parameter int VIRUS_LIMIT     = 500
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_uniform_draw,
  input  logic [15:0] in_burst_virions,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [11:0] out_target_count,
  output logic [11:0] out_eclipse_count,
  output logic [11:0] out_infected_count,
  output logic [15:0] out_virus_count,
  output logic        out_finished,
  output logic        out_survived,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import gves_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_OP   = 8'b0000_0010,
    ST_WAIT = 8'b0000_0100,
    ST_SUM  = 8'b0000_1000,
    ST_CHK  = 8'b0001_0000,
    ST_PICK = 8'b0010_0000,
    ST_UPD  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } gves_state_t;

  typedef enum logic [3:0] {
    OP_CUT_BETA = 4'd0,
    OP_CUT_PROD = 4'd1,
    OP_BT       = 4'd2,
    OP_BTV      = 4'd3,
    OP_ECL      = 4'd4,
    OP_DEATH    = 4'd5,
    OP_PROD     = 4'd6,
    OP_CLEAR    = 4'd7,
    OP_DIV      = 4'd8,
    OP_SCALE    = 4'd9
  } gves_op_t;

  localparam logic [11:0] INIT_T    = 12'(INITIAL_TARGETS);
  localparam logic [15:0] INIT_V    = 16'(INITIAL_VIRUS);
  localparam logic [15:0] VLIM      = 16'(VIRUS_LIMIT);
  localparam logic        INIT_OVER = !((INIT_V != 16'd0) && (INIT_V <= VLIM));

  function automatic logic running(input logic [11:0] e, input logic [11:0] i,
                                   input logic [15:0] v);
    return ((v != 16'd0) || (e != 12'd0) || (i != 12'd0)) && (v <= VLIM);
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] v, input logic [15:0] d);
    logic [16:0] s;
    s = {1'b0, v} + {1'b0, d};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // configuration
  logic        model_r;
  logic [1:0]  scenario_r;
  logic [15:0] efficacy_r;
  logic [31:0] beta_r, ecl_r, death_r, clr_r, prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_r    <= 1'b0;
      scenario_r <= SCEN_PROD_CUT;
      efficacy_r <= '0;
      beta_r     <= 32'd1786;
      ecl_r      <= 32'd83886080;
      death_r    <= 32'd9982444;
      clr_r      <= 32'd167772160;
      prod_r     <= 32'd1879048192;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODEL_SELECT: model_r    <= cfg_data[0];
        CFG_SCENARIO:     scenario_r <= cfg_data[1:0];
        CFG_EFFICACY:     efficacy_r <= cfg_data[15:0];
        CFG_INFECTIVITY:  beta_r     <= cfg_data;
        CFG_ECLIPSE:      ecl_r      <= cfg_data;
        CFG_DEATH:        death_r    <= cfg_data;
        CFG_CLEARANCE:    clr_r      <= cfg_data;
        CFG_PRODUCTION:   prod_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  gves_state_t      state_r, state_nxt;
  gves_op_t         op_r, op_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic [31:0]      u_r, u_nxt;
  logic [15:0]      burst_r, burst_nxt;
  logic [31:0]      beta_q_r, beta_q_nxt, prod_q_r, prod_q_nxt;
  logic [63:0]      rate_r [5];
  logic [63:0]      rate_nxt [5];
  logic [OPA_W-1:0] total_r, total_nxt, cum_r, cum_nxt, cum_sum;
  logic [11:0]      tgt_r, tgt_nxt, ecl_cnt_r, ecl_cnt_nxt, inf_r, inf_nxt;
  logic [15:0]      vir_r, vir_nxt;
  logic             over_r, over_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       o_kind_r, o_kind_nxt;
  logic [11:0]      o_tgt_r, o_tgt_nxt, o_ecl_r, o_ecl_nxt, o_inf_r, o_inf_nxt;
  logic [15:0]      o_vir_r, o_vir_nxt;
  logic             o_fin_r, o_fin_nxt, o_surv_r, o_surv_nxt;

  logic [11:0]      up_t, up_e, up_i;
  logic [15:0]      up_v;

  gves_req_t        req;
  logic [OPA_W-1:0] opa;
  logic [31:0]      opb;
  logic             u_done;
  logic [ACC_W-1:0] u_res;
  logic [16:0]      factor;
  logic             skip;

  gves_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .opa    (opa),
    .opb    (opb),
    .done   (u_done),
    .result (u_res)
  );

  assign factor = 17'h10000 - {1'b0, efficacy_r};

  // operands of the shared unit
  always_comb begin
    opa = '0;
    opb = '0;
    case (op_r)
      OP_CUT_BETA: begin opa = {35'b0, beta_r};      opb = {15'b0, factor}; end
      OP_CUT_PROD: begin opa = {35'b0, prod_r};      opb = {15'b0, factor}; end
      OP_BT:       begin opa = {35'b0, beta_q_r};    opb = {20'b0, tgt_r}; end
      OP_BTV:      begin opa = {3'b0, rate_r[0]};    opb = {16'b0, vir_r}; end
      OP_ECL:      begin opa = {35'b0, ecl_r};       opb = {20'b0, ecl_cnt_r}; end
      OP_DEATH:    begin opa = {35'b0, death_r};     opb = {20'b0, inf_r}; end
      OP_PROD:     begin opa = {35'b0, prod_q_r};    opb = {20'b0, inf_r}; end
      OP_CLEAR:    begin opa = {35'b0, clr_r};       opb = {16'b0, vir_r}; end
      OP_DIV:      begin opa = {3'b0, rate_r[4][47:0], 16'b0}; opb = {15'b0, factor}; end
      OP_SCALE:    begin opa = total_r;              opb = u_r; end
      default: ;
    endcase
  end

  // count update for the chosen event
  always_comb begin
    up_t = tgt_r;
    up_e = ecl_cnt_r;
    up_i = inf_r;
    up_v = vir_r;
    case (kind_r)
      KIND_INFECT: begin
        up_v = vir_r - 16'd1;
        up_t = tgt_r - 12'd1;
        up_e = ecl_cnt_r + 12'd1;
      end
      KIND_ECLIPSE: begin
        up_e = ecl_cnt_r - 12'd1;
        up_i = inf_r + 12'd1;
      end
      KIND_DEATH: begin
        up_i = inf_r - 12'd1;
        if (!model_r) up_v = sat_add(vir_r, burst_r);
      end
      KIND_PROD:  up_v = sat_add(vir_r, 16'd1);
      KIND_CLEAR: up_v = vir_r - 16'd1;
      default: ;
    endcase
  end

  assign cum_sum = cum_r + {3'b0, rate_r[idx_r]};

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    kind_nxt      = kind_r;
    u_nxt         = u_r;
    burst_nxt     = burst_r;
    beta_q_nxt    = beta_q_r;
    prod_q_nxt    = prod_q_r;
    rate_nxt      = rate_r;
    total_nxt     = total_r;
    cum_nxt       = cum_r;
    tgt_nxt       = tgt_r;
    ecl_cnt_nxt   = ecl_cnt_r;
    inf_nxt       = inf_r;
    vir_nxt       = vir_r;
    over_nxt      = over_r;
    out_valid_nxt = out_valid_r;
    o_kind_nxt    = o_kind_r;
    o_tgt_nxt     = o_tgt_r;
    o_ecl_nxt     = o_ecl_r;
    o_inf_nxt     = o_inf_r;
    o_vir_nxt     = o_vir_r;
    o_fin_nxt     = o_fin_r;
    o_surv_nxt    = o_surv_r;
    req           = '0;
    skip          = 1'b0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          u_nxt     = in_uniform_draw;
          burst_nxt = in_burst_virions;
          kind_nxt  = KIND_NONE;
          if (!in_cmd) begin
            tgt_nxt     = INIT_T;
            ecl_cnt_nxt = '0;
            inf_nxt     = '0;
            vir_nxt     = INIT_V;
            over_nxt    = INIT_OVER;
            state_nxt   = ST_OUT;
          end else if (over_r) begin
            state_nxt = ST_OUT;
          end else if (!running(ecl_cnt_r, inf_r, vir_r)) begin
            over_nxt  = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            op_nxt    = OP_CUT_BETA;
            state_nxt = ST_OP;
          end
        end
      end
      ST_OP: begin
        // bypass the operations that the model and scenario leave out
        case (op_r)
          OP_CUT_BETA: begin
            skip       = (scenario_r != SCEN_INFEC_CUT);
            beta_q_nxt = beta_r;
          end
          OP_CUT_PROD: begin
            skip       = (scenario_r != SCEN_PROD_CUT);
            prod_q_nxt = prod_r;
          end
          OP_PROD: begin
            skip        = !model_r;
            rate_nxt[3] = '0;
          end
          OP_DIV: skip = (scenario_r != SCEN_CLEAR_UP);
          default: skip = 1'b0;
        endcase
        if (!skip) begin
          beta_q_nxt  = beta_q_r;
          prod_q_nxt  = prod_q_r;
          rate_nxt[3] = rate_r[3];
          req.start    = 1'b1;
          req.div_mode = (op_r == OP_DIV);
          state_nxt    = ST_WAIT;
        end else if (op_r == OP_DIV) begin
          // point the operands at the draw product for the check step
          op_nxt    = OP_SCALE;
          idx_nxt   = '0;
          total_nxt = '0;
          state_nxt = ST_SUM;
        end else begin
          op_nxt = gves_op_t'(op_r + 4'd1);
        end
      end
      ST_WAIT: begin
        if (u_done) begin
          state_nxt = ST_OP;
          op_nxt    = gves_op_t'(op_r + 4'd1);
          case (op_r)
            OP_CUT_BETA: beta_q_nxt  = u_res[47:16];
            OP_CUT_PROD: prod_q_nxt  = u_res[47:16];
            OP_BT:       rate_nxt[0] = u_res[63:0];
            OP_BTV:      rate_nxt[0] = u_res[63:0];
            OP_ECL:      rate_nxt[1] = u_res[63:0];
            OP_DEATH:    rate_nxt[2] = u_res[63:0];
            OP_PROD:     rate_nxt[3] = u_res[63:0];
            OP_CLEAR:    rate_nxt[4] = u_res[63:0];
            OP_DIV:      rate_nxt[4] = u_res[63:0];
            default: ;
          endcase
          if (op_r == OP_DIV) begin
            idx_nxt   = '0;
            total_nxt = '0;
            state_nxt = ST_SUM;
          end else if (op_r == OP_SCALE) begin
            op_nxt    = OP_SCALE;
            idx_nxt   = '0;
            cum_nxt   = '0;
            state_nxt = ST_PICK;
          end
        end
      end
      ST_SUM: begin
        total_nxt = total_r + {3'b0, rate_r[idx_r]};
        if (idx_r == KIND_CLEAR) state_nxt = ST_CHK;
        else                     idx_nxt   = idx_r + 3'd1;
      end
      ST_CHK: begin
        if (total_r == '0) begin
          kind_nxt  = KIND_NONE;
          state_nxt = ST_OUT;
        end else begin
          op_nxt    = OP_SCALE;
          req.start = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_PICK: begin
        // first event whose running sum exceeds draw times total
        cum_nxt = cum_sum;
        if (u_res < {cum_sum, 32'b0}) begin
          kind_nxt  = idx_r;
          state_nxt = ST_UPD;
        end else if (idx_r == KIND_CLEAR) begin
          kind_nxt  = KIND_NONE;
          state_nxt = ST_UPD;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      ST_UPD: begin
        tgt_nxt     = up_t;
        ecl_cnt_nxt = up_e;
        inf_nxt     = up_i;
        vir_nxt     = up_v;
        over_nxt    = !running(up_e, up_i, up_v);
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt    = kind_r;
          o_tgt_nxt     = tgt_r;
          o_ecl_nxt     = ecl_cnt_r;
          o_inf_nxt     = inf_r;
          o_vir_nxt     = vir_r;
          o_fin_nxt     = over_r;
          o_surv_nxt    = over_r && (vir_r != 16'd0);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_CUT_BETA;
      idx_r       <= '0;
      tgt_r       <= INIT_T;
      ecl_cnt_r   <= '0;
      inf_r       <= '0;
      vir_r       <= INIT_V;
      over_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      idx_r       <= idx_nxt;
      tgt_r       <= tgt_nxt;
      ecl_cnt_r   <= ecl_cnt_nxt;
      inf_r       <= inf_nxt;
      vir_r       <= vir_nxt;
      over_r      <= over_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    u_r      <= u_nxt;
    burst_r  <= burst_nxt;
    beta_q_r <= beta_q_nxt;
    prod_q_r <= prod_q_nxt;
    rate_r   <= rate_nxt;
    total_r  <= total_nxt;
    cum_r    <= cum_nxt;
    o_kind_r <= o_kind_nxt;
    o_tgt_r  <= o_tgt_nxt;
    o_ecl_r  <= o_ecl_nxt;
    o_inf_r  <= o_inf_nxt;
    o_vir_r  <= o_vir_nxt;
    o_fin_r  <= o_fin_nxt;
    o_surv_r <= o_surv_nxt;
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_event_kind     = o_kind_r;
  assign out_target_count   = o_tgt_r;
  assign out_eclipse_count  = o_ecl_r;
  assign out_infected_count = o_inf_r;
  assign out_virus_count    = o_vir_r;
  assign out_finished       = o_fin_r;
  assign out_survived       = o_surv_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    u_done |-> (state_r == ST_WAIT))
    else $error("unit finished outside a wait");

  a_cells_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ({2'b0, tgt_r} + {2'b0, ecl_cnt_r} + {2'b0, inf_r}) <= {2'b0, INIT_T})
    else $error("cell total grew above the initial target count");

  a_pick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK) |-> (total_r != '0))
    else $error("event selection with zero total rate");

endmodule
